[hdl/epic_pkg.sv]
package epic_pkg;

   localparam int TICK_W      = 24;
   localparam int GAIN_W      = 25;
   localparam int THRESH_W    = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 25;

   localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_TICKS  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_GAIN   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_TICKS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_GAIN  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_JUMP_THRESH  = 3'd4;

   localparam logic [TICK_W-1:0]   FIRST_TICKS_RST  = 24'd1000;
   localparam logic [GAIN_W-1:0]   FIRST_GAIN_RST   = 25'd16777;
   localparam logic [TICK_W-1:0]   SECOND_TICKS_RST = 24'd1000;
   localparam logic [GAIN_W-1:0]   SECOND_GAIN_RST  = 25'd16777;
   localparam logic [THRESH_W-1:0] JUMP_THRESH_RST  = 16'd1043;

   typedef enum logic [1:0] {
      PH_FIRST_AVG   = 2'd0,
      PH_JUMP_SEARCH = 2'd1,
      PH_SECOND_AVG  = 2'd2,
      PH_DONE        = 2'd3
   } phase_type;

endpackage

[hdl/encoder_pot_index_calibration.sv]
// pipeline: input stage, then result stage, which loads when the word advances
// throughput: one word per cycle while rsp_tready allows, held by the single
//   multiply-accumulate whose accumulator feeds back into the next word
// reset: synchronous, active high; clears phase, accumulators, tick counter,
//   jump reference and start position, and loads the register defaults
module encoder_pot_index_calibration
   import epic_pkg::*;
#(
   parameter int ANGLE_BITS     = 32,
   parameter int REV_BITS       = 16,
   parameter int GAIN_FRAC_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // unwrapped_angle, raw_angle, pot_angle
   input  logic [((3 * ANGLE_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // calibrated_angle, phase
   output logic [((ANGLE_BITS + 2 + 7) / 8) * 8 - 1:0] rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int A      = ANGLE_BITS;
   localparam int F      = GAIN_FRAC_BITS;
   localparam int R      = REV_BITS;
   localparam int OUT_W  = ((ANGLE_BITS + 2 + 7) / 8) * 8;
   localparam int ACC_W  = A + F + 2;
   localparam int PROD_W = A + 1 + GAIN_W + 1;
   localparam int SUM_W  = ((ACC_W > PROD_W) ? ACC_W : PROD_W) + 1;
   localparam int SH     = R + F;
   localparam int V_W    = ((ACC_W > SH + 1) ? ACC_W : SH + 1) + 2;
   localparam int S_W    = ((A > R + 1) ? A : R + 1) + 1;
   localparam int R1_W   = V_W - SH;
   localparam int R2_W   = S_W - R;
   localparam int D_W    = ((R1_W > R2_W) ? R1_W : R2_W) + 1;
   localparam int Q_W    = D_W + SH;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W - 1){1'b0}}};
   localparam logic signed [A-1:0]     ANG_MAX = {1'b0, {(A - 1){1'b1}}};
   localparam logic signed [A-1:0]     ANG_MIN = {1'b1, {(A - 1){1'b0}}};
   localparam logic signed [V_W-1:0]   HALF_V  = {{(V_W - 1){1'b0}}, 1'b1} << (SH - 1);
   localparam logic signed [S_W-1:0]   HALF_S  = {{(S_W - 1){1'b0}}, 1'b1} << (R - 1);

   // configuration
   logic [TICK_W-1:0]   first_ticks_ff, second_ticks_ff;
   logic [GAIN_W-1:0]   first_gain_ff, second_gain_ff;
   logic [THRESH_W-1:0] jump_thresh_ff;

   // calibration state
   phase_type              phase_ff, phase_in;
   logic signed [ACC_W-1:0] offset_ff, offset_in;
   logic signed [ACC_W-1:0] second_acc_ff, second_acc_in;
   logic [TICK_W-1:0]       tick_ff, tick_in;
   logic signed [A-1:0]     start_ff, start_in;
   logic signed [A:0]       ref_ff, ref_in;

   // input and result stages
   logic                in_valid_ff;
   logic signed [A-1:0] in_unw_ff, in_raw_ff, in_pot_ff;
   logic                out_valid_ff;
   logic [A-1:0]        out_cal_ff;
   phase_type           out_phase_ff;
   logic                advance;

   // datapath
   logic signed [A:0]        diff;
   logic [GAIN_W-1:0]        gain_sel;
   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]  acc_sel;
   logic signed [SUM_W-1:0]  acc_sum;
   logic [SUM_W-ACC_W:0]     acc_top;
   logic signed [ACC_W-1:0]  acc_sat;
   logic signed [A+2:0]      cal_sum;
   logic [3:0]               cal_top;
   logic signed [A-1:0]      cal;
   logic signed [A:0]        rel;
   logic signed [A+1:0]      jd;
   logic [A+1:0]             jd_abs;
   logic                     jump;
   logic [TICK_W:0]          elapsed;
   logic                     second_done;
   logic signed [V_W-1:0]    v;
   logic signed [S_W-1:0]    s2;
   logic signed [D_W-1:0]    dq;
   logic signed [Q_W-1:0]    q;
   logic [Q_W-ACC_W:0]       q_top;
   logic signed [ACC_W-1:0]  q_sat;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = OUT_W'({out_phase_ff, out_cal_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ticks_ff  <= FIRST_TICKS_RST;
         first_gain_ff   <= FIRST_GAIN_RST;
         second_ticks_ff <= SECOND_TICKS_RST;
         second_gain_ff  <= SECOND_GAIN_RST;
         jump_thresh_ff  <= JUMP_THRESH_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FIRST_TICKS:  first_ticks_ff  <= TICK_W'(csr_data);
            CSR_FIRST_GAIN:   first_gain_ff   <= GAIN_W'(csr_data);
            CSR_SECOND_TICKS: second_ticks_ff <= TICK_W'(csr_data);
            CSR_SECOND_GAIN:  second_gain_ff  <= GAIN_W'(csr_data);
            CSR_JUMP_THRESH:  jump_thresh_ff  <= THRESH_W'(csr_data);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
      if (req_tvalid && req_tready) begin
         in_unw_ff <= $signed(req_tdata[A-1:0]);
         in_raw_ff <= $signed(req_tdata[2*A-1:A]);
         in_pot_ff <= $signed(req_tdata[3*A-1:2*A]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_cal_ff   <= cal;
         out_phase_ff <= phase_ff;
      end
   end

   // shared multiply-accumulate
   always_comb begin
      diff     = (A + 1)'(in_pot_ff) - (A + 1)'(in_unw_ff);
      gain_sel = (phase_ff == PH_SECOND_AVG) ? second_gain_ff : first_gain_ff;
      prod     = PROD_W'(diff) * PROD_W'($signed({1'b0, gain_sel}));
      acc_sel  = (phase_ff == PH_SECOND_AVG) ? second_acc_ff : offset_ff;
      acc_sum  = SUM_W'(acc_sel) + SUM_W'(prod);
      acc_top  = acc_sum[SUM_W-1:ACC_W-1];
      if (&acc_top || ~|acc_top) begin
         acc_sat = acc_sum[ACC_W-1:0];
      end else if (acc_sum[SUM_W-1]) begin
         acc_sat = ACC_MIN;
      end else begin
         acc_sat = ACC_MAX;
      end
   end

   // calibrated angle from the offset held before this word
   always_comb begin
      cal_sum = (A + 3)'(in_unw_ff) + (A + 3)'($signed(offset_ff[ACC_W-1:F]));
      cal_top = cal_sum[A+2:A-1];
      if (&cal_top || ~|cal_top) begin
         cal = cal_sum[A-1:0];
      end else if (cal_sum[A+2]) begin
         cal = ANG_MIN;
      end else begin
         cal = ANG_MAX;
      end
   end

   // jump search and end of second window
   always_comb begin
      rel         = (A + 1)'(in_raw_ff) - (A + 1)'(in_unw_ff);
      jd          = (A + 2)'(rel) - (A + 2)'(ref_ff);
      jd_abs      = jd[A+1] ? (A + 2)'(-jd) : (A + 2)'(jd);
      jump        = jd_abs > (A + 2)'(jump_thresh_ff);
      elapsed     = {1'b0, tick_ff} + (TICK_W + 1)'(1);
      second_done = elapsed > {1'b0, second_ticks_ff};
   end

   // whole-revolution offset, rounding half up
   always_comb begin
      v     = V_W'(second_acc_ff) + (V_W'(start_ff) <<< F) + HALF_V;
      s2    = S_W'(start_ff) + HALF_S;
      dq    = D_W'($signed(v[V_W-1:SH])) - D_W'($signed(s2[S_W-1:R]));
      q     = $signed({dq, {SH{1'b0}}});
      q_top = q[Q_W-1:ACC_W-1];
      if (&q_top || ~|q_top) begin
         q_sat = q[ACC_W-1:0];
      end else if (q[Q_W-1]) begin
         q_sat = ACC_MIN;
      end else begin
         q_sat = ACC_MAX;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      offset_in     = offset_ff;
      second_acc_in = second_acc_ff;
      tick_in       = tick_ff;
      start_in      = start_ff;
      ref_in        = ref_ff;
      if (advance) begin
         case (phase_ff)
            PH_FIRST_AVG: begin
               if (tick_ff >= first_ticks_ff) begin
                  ref_in   = rel;
                  phase_in = PH_JUMP_SEARCH;
               end else begin
                  offset_in = acc_sat;
               end
               if (tick_ff != TICK_MAX) begin
                  tick_in = tick_ff + TICK_W'(1);
               end
            end
            PH_JUMP_SEARCH: begin
               if (jump) begin
                  start_in = in_unw_ff;
                  tick_in  = '0;
                  phase_in = PH_SECOND_AVG;
               end
            end
            PH_SECOND_AVG: begin
               if (second_done) begin
                  offset_in = q_sat;
                  phase_in  = PH_DONE;
               end else begin
                  second_acc_in = acc_sat;
                  tick_in       = elapsed[TICK_W-1:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_FIRST_AVG;
         offset_ff     <= '0;
         second_acc_ff <= '0;
         tick_ff       <= '0;
         start_ff      <= '0;
         ref_ff        <= '0;
      end else begin
         phase_ff      <= phase_in;
         offset_ff     <= offset_in;
         second_acc_ff <= second_acc_in;
         tick_ff       <= tick_in;
         start_ff      <= start_in;
         ref_ff        <= ref_in;
      end
   end

   a_phase_forward : assert property (@(posedge clock) disable iff (reset)
      advance |=> (phase_ff == $past(phase_ff))
                  || (2'(phase_ff) == 2'(2'($past(phase_ff)) + 2'd1)))
      else $error("phase moved other than one step forward");

   a_phase_held : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(phase_ff) && $stable(offset_ff))
      else $error("calibration state changed without a word");

   a_done_offset : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE) |=> $stable(offset_ff) && (phase_ff == PH_DONE))
      else $error("offset changed after calibration finished");

   a_result_source : assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(in_valid_ff))
      else $error("result word appeared without an input word");

endmodule
